[rtl/mep_pkg.sv]
// Shared types, constants and helpers for the escape-time pixel unit.
`timescale 1ns / 1ps

package mep_pkg;

   localparam int FRAC_BITS    = 10;
   localparam int FRAME_WIDTH  = 128;
   localparam int FRAME_HEIGHT = 128;
   localparam int DATA_WIDTH   = 32;

   localparam int POINT_W = 24;
   localparam int COL_W   = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
   localparam int ROW_W   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 16;

   localparam logic [15:0] X_START_RST = 16'hF800;
   localparam logic [15:0] Y_START_RST = 16'hF800;
   localparam logic [11:0] X_STEP_RST  = 12'd32;
   localparam logic [11:0] Y_STEP_RST  = 12'd32;
   localparam logic [15:0] LIMIT_RST   = 16'd4096;
   localparam logic [3:0]  MAX_ITER_RST = 4'd15;

   typedef enum logic [CSR_AW-1:0] {
      CSR_X_START  = 3'd0,
      CSR_Y_START  = 3'd1,
      CSR_X_STEP   = 3'd2,
      CSR_Y_STEP   = 3'd3,
      CSR_LIMIT    = 3'd4,
      CSR_MAX_ITER = 3'd5
   } csr_addr_type;

   typedef struct packed {
      logic [15:0] x_start;
      logic [15:0] y_start;
      logic [11:0] x_step;
      logic [11:0] y_step;
      logic [15:0] escape_limit;
      logic [3:0]  max_iter;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic frame_start;
      logic multiply;
      logic update;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic max_iter_zero;
      logic escape;
      logic iter_last;
   } dp_status_type;

   typedef struct packed {
      logic       frame_last;
      logic [6:0] pixel_row;
      logic [6:0] pixel_col;
      logic [5:0] second_byte;
      logic [6:0] first_byte;
      logic [3:0] iter_left;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Sign-extend a 16-bit start coordinate into the point domain.
   function automatic logic [POINT_W-1:0] widen_start(input logic [15:0] v);
      widen_start = POINT_W'($signed(v));
   endfunction

endpackage

[rtl/mep_ctrl.sv]
// Sequencer for one pixel: seed, multiply/update passes, result handoff.
`timescale 1ns / 1ps

module mep_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_frame_start,
   input  logic                   out_free,
   input  mep_pkg::dp_status_type status,
   output logic                   req_tready,
   output mep_pkg::dp_cmd_type    cmd
);
   import mep_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.frame_start = req_frame_start;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = status.max_iter_zero ? ST_FINISH : ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.multiply = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = (status.escape || status.iter_last) ? ST_FINISH : ST_MULT;
         end
         ST_FINISH: begin
            // hold until the output register can take the transaction
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/mep_datapath.sv]
// Point and scan counters, Z registers, products and escape countdown.
`timescale 1ns / 1ps

module mep_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mep_pkg::cfg_type       cfg,
   input  mep_pkg::dp_cmd_type    cmd,
   output mep_pkg::dp_status_type status,
   output mep_pkg::result_type    result
);
   import mep_pkg::*;

   logic [POINT_W-1:0] point_real_ff, point_real_in;
   logic [POINT_W-1:0] point_imag_ff, point_imag_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic signed [DATA_WIDTH-1:0] zr_ff, zi_ff, cr_ff, ci_ff;
   logic signed [DATA_WIDTH-1:0] prr_ff, pii_ff, pri_ff;
   logic [3:0]                   iter_ff;

   logic [POINT_W-1:0]           seed_real, seed_imag;
   logic signed [DATA_WIDTH-1:0] zrr, zii, zri, norm, limit_ext;
   logic                         col_end, row_end;

   // Restart applies before the pixel is seeded.
   assign seed_real = cmd.frame_start ? widen_start(cfg.x_start) : point_real_ff;
   assign seed_imag = cmd.frame_start ? widen_start(cfg.y_start) : point_imag_ff;

   assign zrr       = prr_ff >>> FRAC_BITS;
   assign zii       = pii_ff >>> FRAC_BITS;
   assign zri       = pri_ff >>> (FRAC_BITS - 1);
   assign norm      = zrr + zii;
   assign limit_ext = DATA_WIDTH'(cfg.escape_limit);

   assign status.max_iter_zero = (cfg.max_iter == 4'd0);
   assign status.escape        = (norm > limit_ext);
   assign status.iter_last     = (iter_ff == 4'd1);

   assign col_end = (col_ff == COL_W'(FRAME_WIDTH - 1));
   assign row_end = (row_ff == ROW_W'(FRAME_HEIGHT - 1));

   assign result.iter_left   = iter_ff;
   assign result.first_byte  = {iter_ff, 3'b000};
   assign result.second_byte = {iter_ff, 2'b00};
   assign result.pixel_col   = 7'(col_ff);
   assign result.pixel_row   = 7'(row_ff);
   assign result.frame_last  = col_end && row_end;

   always_comb begin
      point_real_in = point_real_ff;
      point_imag_in = point_imag_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      if (cmd.start && cmd.frame_start) begin
         point_real_in = seed_real;
         point_imag_in = seed_imag;
         col_in        = '0;
         row_in        = '0;
      end else if (cmd.finish) begin
         if (!col_end) begin
            col_in        = col_ff + COL_W'(1);
            point_real_in = point_real_ff + POINT_W'(cfg.x_step);
         end else if (!row_end) begin
            col_in        = '0;
            row_in        = row_ff + ROW_W'(1);
            point_real_in = widen_start(cfg.x_start);
            point_imag_in = point_imag_ff + POINT_W'(cfg.y_step);
         end else begin
            col_in        = '0;
            row_in        = '0;
            point_real_in = widen_start(cfg.x_start);
            point_imag_in = widen_start(cfg.y_start);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_real_ff <= widen_start(X_START_RST);
         point_imag_ff <= widen_start(Y_START_RST);
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         point_real_ff <= point_real_in;
         point_imag_ff <= point_imag_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         zr_ff   <= DATA_WIDTH'($signed(seed_real));
         zi_ff   <= DATA_WIDTH'($signed(seed_imag));
         cr_ff   <= DATA_WIDTH'($signed(seed_real));
         ci_ff   <= DATA_WIDTH'($signed(seed_imag));
         iter_ff <= cfg.max_iter;
      end else if (cmd.update && !status.escape) begin
         zr_ff   <= zrr - zii + cr_ff;
         zi_ff   <= zri + ci_ff;
         iter_ff <= iter_ff - 4'd1;
      end
      // low DATA_WIDTH bits of each product
      if (cmd.multiply) begin
         prr_ff <= zr_ff * zr_ff;
         pii_ff <= zi_ff * zi_ff;
         pri_ff <= zr_ff * zi_ff;
      end
   end

endmodule

[rtl/mandelbrot_escape_pixel_unit.sv]
// Top level: configuration registers, sequencer, datapath, result register.
`timescale 1ns / 1ps

// Each accepted request produces the next pixel of a raster scan with its
// escape-time count. After acceptance the pixel runs n escape passes, where
// n is 1 to max_iter (0 when max_iter is 0): each pass runs the three
// multipliers and then the update and norm compare. A seeding step comes
// before the passes and a handoff step after them; the handoff waits until
// the output register is free. The result sits in an output register, so a
// new request is taken while the previous result still waits on rsp_tready.

module mandelbrot_escape_pixel_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // [0] frame_start
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [3:0] iter_left, [10:4] first_byte, [16:11] second_byte,
   // [23:17] pixel_col, [30:24] pixel_row
   output logic [31:0]                 rsp_tdata,
   output logic                        rsp_tlast,  // frame_last
   input  logic                        csr_we,
   input  logic [mep_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [mep_pkg::CSR_DW-1:0]  csr_wdata
);
   import mep_pkg::*;

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result;
   logic          out_free;
   logic          rsp_valid_ff;
   result_type    rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_start      <= X_START_RST;
         cfg_ff.y_start      <= Y_START_RST;
         cfg_ff.x_step       <= X_STEP_RST;
         cfg_ff.y_step       <= Y_STEP_RST;
         cfg_ff.escape_limit <= LIMIT_RST;
         cfg_ff.max_iter     <= MAX_ITER_RST;
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_X_START:  cfg_ff.x_start      <= csr_wdata;
            CSR_Y_START:  cfg_ff.y_start      <= csr_wdata;
            CSR_X_STEP:   cfg_ff.x_step       <= csr_wdata[11:0];
            CSR_Y_STEP:   cfg_ff.y_step       <= csr_wdata[11:0];
            CSR_LIMIT:    cfg_ff.escape_limit <= csr_wdata;
            CSR_MAX_ITER: cfg_ff.max_iter     <= csr_wdata[3:0];
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   mep_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_frame_start (req_tdata[0]),
      .out_free        (out_free),
      .status          (status),
      .req_tready      (req_tready),
      .cmd             (cmd)
   );

   mep_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .status (status),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.frame_last;
   assign rsp_tdata  = {1'b0, rsp_ff.pixel_row, rsp_ff.pixel_col, rsp_ff.second_byte,
                        rsp_ff.first_byte, rsp_ff.iter_left};

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the escape-time pixel unit: directed, stall and random scans.
`timescale 1ns / 1ps

module tb_top;
   import mep_pkg::*;

   // Spare register indexes: writes to them must leave every register alone.
   localparam logic [CSR_AW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_SPARE_HI = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;   // [0] frame_start
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [3:0] iter_left, [10:4] first_byte, [16:11] second_byte,
   // [23:17] pixel_col, [30:24] pixel_row
   logic [31:0]         rsp_tdata;
   logic                rsp_tlast;         // frame_last
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   // Local copy of the scan: registers, current point and raster position.
   cfg_type             scan_cfg;
   logic [POINT_W-1:0]  scan_real;
   logic [POINT_W-1:0]  scan_imag;
   int                  scan_col;
   int                  scan_row;

   result_type          expected_pixels[$];
   int                  mismatch_count = 0;
   int                  req_idle_level = 2;
   int                  rsp_idle_level = 2;
   int                  rsp_hold_cycles = 0;

   mandelbrot_escape_pixel_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("FAIL mandelbrot_escape_pixel_unit");
      $finish;
   end

   // Level 0: no idling, 1: short gaps only, 2: short gaps and a few long ones.
   function automatic int gap_cycles(input int level);
      int r;
      r = $urandom_range(0, 99);
      if (level == 0 || r < 60) return 0;
      if (r < 92 || level == 1) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic restart_scan();
      scan_col  = 0;
      scan_row  = 0;
      scan_real = {{(POINT_W-16){scan_cfg.x_start[15]}}, scan_cfg.x_start};
      scan_imag = {{(POINT_W-16){scan_cfg.y_start[15]}}, scan_cfg.y_start};
   endtask

   task automatic reset_model();
      scan_cfg.x_start      = X_START_RST;
      scan_cfg.y_start      = Y_START_RST;
      scan_cfg.x_step       = X_STEP_RST;
      scan_cfg.y_step       = Y_STEP_RST;
      scan_cfg.escape_limit = LIMIT_RST;
      scan_cfg.max_iter     = MAX_ITER_RST;
      restart_scan();
   endtask

   // Run the escape loop for the current point, queue the pixel, step the raster.
   task automatic compute_pixel(input logic restart);
      logic signed [DATA_WIDTH-1:0] c_re, c_im, z_re, z_im;
      logic signed [DATA_WIDTH-1:0] sq_re, sq_im, cross_term, norm, limit;
      logic [DATA_WIDTH-1:0]        prod;
      logic [3:0]                   count;
      logic                         escaped;
      result_type                   px;
      if (restart) restart_scan();
      c_re  = {{(DATA_WIDTH-POINT_W){scan_real[POINT_W-1]}}, scan_real};
      c_im  = {{(DATA_WIDTH-POINT_W){scan_imag[POINT_W-1]}}, scan_imag};
      limit = {{(DATA_WIDTH-16){1'b0}}, scan_cfg.escape_limit};
      z_re  = c_re;
      z_im  = c_im;
      count = scan_cfg.max_iter;
      escaped = 1'b0;
      while (count != 0 && !escaped) begin
         prod  = z_re * z_re;
         sq_re = $signed(prod) >>> FRAC_BITS;
         prod  = z_im * z_im;
         sq_im = $signed(prod) >>> FRAC_BITS;
         prod  = z_re * z_im;
         cross_term = $signed(prod) >>> (FRAC_BITS - 1);
         z_re  = sq_re - sq_im + c_re;
         z_im  = cross_term + c_im;
         norm  = sq_re + sq_im;
         if (norm > limit) escaped = 1'b1;
         else count = count - 4'd1;
      end
      px.iter_left   = count;
      px.first_byte  = {count, 3'b000};
      px.second_byte = {count, 2'b00};
      px.pixel_col   = 7'(scan_col);
      px.pixel_row   = 7'(scan_row);
      px.frame_last  = (scan_col == FRAME_WIDTH - 1) && (scan_row == FRAME_HEIGHT - 1);
      expected_pixels.push_back(px);

      if (scan_col + 1 < FRAME_WIDTH) begin
         scan_col++;
         scan_real = scan_real + {{(POINT_W-12){1'b0}}, scan_cfg.x_step};
      end else if (scan_row + 1 < FRAME_HEIGHT) begin
         scan_col  = 0;
         scan_row++;
         scan_real = {{(POINT_W-16){scan_cfg.x_start[15]}}, scan_cfg.x_start};
         scan_imag = scan_imag + {{(POINT_W-12){1'b0}}, scan_cfg.y_step};
      end else begin
         restart_scan();
      end
   endtask

   // Offer one request; keep tvalid high into the next call when no gap follows.
   task automatic send_request(input logic frame_start, input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, frame_start};
      do @(posedge clock); while (!req_tready);
      compute_pixel(frame_start);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and hold until every queued pixel has come back.
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller drops it after its last write.
   task automatic write_reg(input logic [CSR_AW-1:0] addr, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         CSR_X_START:  scan_cfg.x_start      = value;
         CSR_Y_START:  scan_cfg.y_start      = value;
         CSR_X_STEP:   scan_cfg.x_step       = value[11:0];
         CSR_Y_STEP:   scan_cfg.y_step       = value[11:0];
         CSR_LIMIT:    scan_cfg.escape_limit = value;
         CSR_MAX_ITER: scan_cfg.max_iter     = value[3:0];
         default: ;
      endcase
   endtask

   // Write all six registers; unused upper data bits carry random junk.
   task automatic load_config(input logic [15:0] x0, input logic [15:0] y0,
                              input logic [11:0] xs, input logic [11:0] ys,
                              input logic [15:0] lim, input logic [3:0] mi);
      write_reg(CSR_X_START, x0);
      write_reg(CSR_Y_START, y0);
      write_reg(CSR_X_STEP, {4'($urandom), xs});
      write_reg(CSR_Y_STEP, {4'($urandom), ys});
      write_reg(CSR_LIMIT, lim);
      write_reg(CSR_MAX_ITER, {12'($urandom), mi});
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      got.iter_left   = rsp_tdata[3:0];
      got.first_byte  = rsp_tdata[10:4];
      got.second_byte = rsp_tdata[16:11];
      got.pixel_col   = rsp_tdata[23:17];
      got.pixel_row   = rsp_tdata[30:24];
      got.frame_last  = rsp_tlast;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected pixel: iter %0d col %0d row %0d last %0b",
                        got.iter_left, got.pixel_col, got.pixel_row, got.frame_last);
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("pixel mismatch: expected iter %0d bytes %0d/%0d col %0d row %0d last %0b",
                           want.iter_left, want.first_byte, want.second_byte,
                           want.pixel_col, want.pixel_row, want.frame_last);
                  $display("                got      iter %0d bytes %0d/%0d col %0d row %0d last %0b",
                           got.iter_left, got.first_byte, got.second_byte,
                           got.pixel_col, got.pixel_row, got.frame_last);
               end
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = gap_cycles(rsp_idle_level);
         end
      end
   end

   // Reset values and a mid-row restart.
   task automatic test_reset_scan();
      int i;
      for (i = 0; i < 6; i++)
         send_request(i == 3, gap_cycles(req_idle_level));
      drain_pixels();
   endtask

   task automatic test_register_extremes();
      int i;
      // Most negative x start, most positive y start, widest x step, no y step, widest limit.
      load_config(16'h8000, 16'h7FFF, 12'hFFF, 12'h000, 16'hFFFF, 4'd15);
      for (i = 0; i < 3; i++) send_request(i == 0, gap_cycles(req_idle_level));
      drain_pixels();
      // Loop never runs when the countdown starts at zero.
      load_config(16'h7FFF, 16'h8000, 12'h000, 12'hFFF, 16'h0000, 4'd0);
      for (i = 0; i < 2; i++) send_request(1'b1, gap_cycles(req_idle_level));
      drain_pixels();
      // Origin never escapes, even against a zero limit.
      load_config(16'h0000, 16'h0000, 12'd1, 12'd1, 16'h0000, 4'd1);
      for (i = 0; i < 2; i++) send_request(i == 0, gap_cycles(req_idle_level));
      drain_pixels();
      // Spare indexes must be ignored.
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'h5A5A);
      csr_we <= 1'b0;
      for (i = 0; i < 2; i++) send_request(1'b0, gap_cycles(req_idle_level));
      drain_pixels();
   endtask

   // A new start coordinate only applies once the point reloads.
   task automatic test_start_reload();
      int i;
      load_config(16'hF800, 16'hFC00, 12'd32, 12'd32, 16'd4096, 4'd15);
      for (i = 0; i < 2; i++) send_request(i == 0, gap_cycles(req_idle_level));
      drain_pixels();
      write_reg(CSR_X_START, 16'h0200);
      csr_we <= 1'b0;
      send_request(1'b0, gap_cycles(req_idle_level));
      send_request(1'b1, gap_cycles(req_idle_level));
      send_request(1'b0, gap_cycles(req_idle_level));
      drain_pixels();
   endtask

   // Hold the result side off while requests keep coming, so the input stalls.
   task automatic test_output_stall();
      int i;
      load_config(16'hF800, 16'hF800, 12'd32, 12'd32, 16'd4096, 4'd3);
      rsp_hold_cycles = 400;
      for (i = 0; i < 12; i++) send_request(1'b0, 0);
      drain_pixels();
   endtask

   task automatic test_random_scan();
      int          phase, i;
      logic [15:0] x0, y0, lim;
      logic [11:0] xs, ys;
      logic [3:0]  mi;
      for (phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 2))
            0: begin
               x0 = 16'($urandom);
               y0 = 16'($urandom);
            end
            1: begin
               x0 = 16'(-2560 + $urandom_range(0, 1536));
               y0 = 16'(-1536 + $urandom_range(0, 1536));
            end
            default: begin
               x0 = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
               y0 = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            end
         endcase
         xs  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 48));
         ys  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 48));
         lim = ($urandom_range(0, 1) != 0) ? 16'd4096 : 16'($urandom);
         mi  = 4'($urandom_range(0, 15));
         load_config(x0, y0, xs, ys, lim, mi);
         // First phase runs without any idling on either side.
         req_idle_level = (phase == 0) ? 0 : $urandom_range(1, 2);
         rsp_idle_level = (phase == 0) ? 0 : $urandom_range(1, 2);
         for (i = 0; i < 176; i++) begin
            send_request($urandom_range(0, 49) == 0, gap_cycles(req_idle_level));
            if ($urandom_range(0, 149) == 0) drain_pixels();
         end
         drain_pixels();
      end
      req_idle_level = 2;
      rsp_idle_level = 2;
   endtask

   // Walk two full rows with max_iter 1 to see the row wrap and reload.
   task automatic test_row_wrap();
      int i;
      load_config(16'hF800, 16'hFA00, 12'd32, 12'd24, 16'd4096, 4'd1);
      req_idle_level = 1;
      rsp_idle_level = 1;
      for (i = 0; i < 2 * FRAME_WIDTH + 3; i++)
         send_request(i == 0, gap_cycles(req_idle_level));
      drain_pixels();
      req_idle_level = 2;
      rsp_idle_level = 2;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      reset_model();
      test_reset_scan();
      test_register_extremes();
      test_start_reload();
      test_output_stall();
      test_random_scan();
      test_row_wrap();
      drain_pixels();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("PASS mandelbrot_escape_pixel_unit");
      else
         $display("FAIL mandelbrot_escape_pixel_unit");
      $finish;
   end

endmodule
